>>> rtl/tlpt_pkg.sv
`default_nettype none

package tlpt_pkg;

  // operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VPAGE_W     = 20;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned FLAGS_W     = 12;
  localparam int unsigned IDX_W       = 10;  // directory and table index width
  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned ENTRY_W     = 32;  // second-level entry: frame, flags
  localparam int unsigned IN_W        = 56;  // request tdata, padded to bytes
  localparam int unsigned OUT_W       = 24;  // result tdata, padded to bytes

  // request fields as held for the duration of one operation
  typedef struct packed {
    logic [FLAGS_W-1:0] entry_flags;
    logic [FRAME_W-1:0] phys_frame;
    logic [VPAGE_W-1:0] virt_page;
    logic [OP_W-1:0]    op;
  } req_t;

  // result fields, status in the lowest bit
  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               mapped;
    logic               status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tlpt_ram.sv
`default_nettype none

module tlpt_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, held between read enables
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/two_level_page_table_engine_unit.sv
// Two-level page table engine. Requests enter on s_axis (tdata from bit 0:
// op[1:0], virt_page[21:2], phys_frame[41:22], entry_flags[53:42]) and one
// result per request leaves on m_axis (status[0], mapped[1],
// frame_out[21:2]). The directory (1024 entries) and the table pool
// (TABLE_SLOTS x 1024 entries of 32 bits) sit in synchronous RAMs with
// registered reads. After reset a clearing pass writes zeros through the
// pool, one entry a cycle (the directory is cleared alongside); no request
// is taken until it ends. Then a map or unmap reads the directory and then
// does the dependent table write, an unknown op only reads the directory,
// and a query reads the directory, then the table, then gives its result.
// One request is in flight at a time; a new request is taken while the
// previous result still waits in the output register. Table slots are
// handed out in order on the first map into a directory entry and are never
// freed; a map that needs a slot when all are taken reports status 1.
`default_nettype none

module two_level_page_table_engine_unit
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // op[1:0], virt_page[21:2], phys_frame[41:22], entry_flags[53:42]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // status[0], mapped[1], frame_out[21:2]
  output logic      [OUT_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready
);

  localparam int unsigned POOL_DEPTH = TABLE_SLOTS * DIR_ENTRIES;
  localparam int unsigned PA_W       = $clog2(POOL_DEPTH);
  localparam int unsigned SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned DENT_W     = SLOT_W + 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_POOL
  } state_e;

  // directory entry: present bit over slot index
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } dent_t;

  state_e           state_q, state_d;
  logic [PA_W-1:0]  clr_q, clr_d;
  logic [CNT_W-1:0] slots_q, slots_d;
  req_t             req_q, req_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic              in_req;
  logic              out_free;
  req_t              in_req_data;
  dent_t             dent_rd;
  dent_t             dent_wr;
  logic [DENT_W-1:0] dir_rdata;
  logic              dir_we;
  logic [IDX_W-1:0]  dir_waddr;
  logic [IDX_W-1:0]  didx;
  logic [IDX_W-1:0]  tidx;
  logic              pool_we;
  logic [PA_W-1:0]   pool_waddr;
  logic [ENTRY_W-1:0] pool_wdata;
  logic              pool_re;
  logic [PA_W-1:0]   pool_addr;
  logic [ENTRY_W-1:0] pool_rdata;
  logic [SLOT_W-1:0] use_slot;
  logic              pool_full;
  logic              do_alloc;

  assign in_req_data   = req_t'(s_axis_tdata[$bits(req_t)-1:0]);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W - $bits(res_t)){1'b0}}, res_q};

  assign dent_rd   = dent_t'(dir_rdata);
  assign didx      = req_q.virt_page[VPAGE_W-1 -: IDX_W];
  assign tidx      = req_q.virt_page[IDX_W-1:0];
  assign pool_full = (slots_q == CNT_W'(TABLE_SLOTS));
  assign do_alloc  = (op_e'(req_q.op) == OP_MAP) && !dent_rd.present && !pool_full;
  assign use_slot  = dent_rd.present ? dent_rd.slot : slots_q[SLOT_W-1:0];
  assign pool_addr = PA_W'({use_slot, tidx});

  // directory: read on request, written by the clear pass and by allocation
  always_comb begin
    dent_wr   = '0;
    dir_we    = 1'b0;
    dir_waddr = clr_q[IDX_W-1:0];
    if (state_q == S_CLEAR) begin
      dir_we = 1'b1;
    end else if ((state_q == S_DIR) && out_free && do_alloc) begin
      dir_we          = 1'b1;
      dir_waddr       = didx;
      dent_wr.present = 1'b1;
      dent_wr.slot    = slots_q[SLOT_W-1:0];
    end
  end

  // table pool: clear pass, map and unmap writes, query reads
  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = clr_q;
    pool_wdata = '0;
    pool_re    = 1'b0;
    if (state_q == S_CLEAR) begin
      pool_we = 1'b1;
    end else if ((state_q == S_DIR) && out_free) begin
      pool_waddr = pool_addr;
      case (op_e'(req_q.op))
        OP_MAP: begin
          pool_we    = dent_rd.present || !pool_full;
          pool_wdata = {req_q.phys_frame, req_q.entry_flags | FLAGS_W'(1)};
        end
        OP_UNMAP: begin
          pool_we = dent_rd.present;
        end
        OP_QUERY: begin
          pool_re = dent_rd.present;
        end
        default: begin
        end
      endcase
    end
  end

  tlpt_ram #(
    .WIDTH  (DENT_W),
    .DEPTH  (DIR_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (DENT_W'(dent_wr)),
    .re_i    (in_req),
    .raddr_i (in_req_data.virt_page[VPAGE_W-1 -: IDX_W]),
    .rdata_o (dir_rdata)
  );

  tlpt_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (POOL_DEPTH),
    .ADDR_W (PA_W)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .re_i    (pool_re),
    .raddr_i (pool_addr),
    .rdata_o (pool_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slots_d     = slots_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + PA_W'(1);
        if (clr_q == PA_W'(POOL_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req) begin
          req_d   = in_req_data;
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        if (out_free) begin
          if (do_alloc) begin
            slots_d = slots_q + CNT_W'(1);
          end
          if ((op_e'(req_q.op) == OP_QUERY) && dent_rd.present) begin
            state_d = S_POOL;
          end else begin
            res_d        = '0;
            res_d.status = (op_e'(req_q.op) == OP_MAP) && !dent_rd.present && pool_full;
            out_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_POOL: begin
        if (out_free) begin
          res_d.status    = 1'b0;
          res_d.mapped    = pool_rdata[0];
          res_d.frame_out = pool_rdata[ENTRY_W-1 -: FRAME_W];
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, request and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      slots_q     <= '0;
      req_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      slots_q     <= slots_d;
      req_q       <= req_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  // allocation never passes the pool size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_q <= CNT_W'(TABLE_SLOTS))
    else $error("slot counter beyond pool size");

  // a slot is only taken by a map request in the directory step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slots_q != $past(slots_q)) |->
      ($past(state_q) == S_DIR) && (op_e'($past(req_q.op)) == OP_MAP))
    else $error("slot counter moved outside a map");

  // a result only appears at the end of the directory or pool step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (($past(state_q) == S_DIR) || ($past(state_q) == S_POOL)))
    else $error("result raised outside a finishing step");

  // no request result is produced while clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !out_valid_q)
    else $error("result produced during clearing pass");

endmodule

`default_nettype wire
